// ===== rtl/core/isp_pkg.sv =====
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps

package isp_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int KEY_W       = 32;

	typedef logic signed [KEY_W-1:0] key_t;

	// What one cell shows to its neighbours
	typedef struct packed {
		logic vld;
		logic gt;
		key_t key;
	} isp_link_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic ins;
		logic shift;
		key_t key;
	} isp_ctrl_t;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

endpackage

// ===== rtl/core/insertion_sorter_unit.sv =====
// Top level of the insertion sorter: cell chain, run control and output register.
//
//  channel  | signals                          | content
//  ---------+----------------------------------+-----------------------------------
//  s_axis   | tvalid tready tdata[31:0] tlast  | key, tlast marks last key of run
//  m_axis   | tvalid tready tdata[31:0] tlast  | sorted_key, tlast = run_end,
//           | tuser[0]                         | tuser = overflowed
//
// A key is inserted into the chain of cells in the cycle it is accepted, so keys
// of a run are taken one per cycle. After the last key the chain shifts down one
// place per result, and no key is accepted until all stored keys of the run have
// drained. Reset empties the chain at once; m_axis_tready low holds the output
// register and stalls the drain.
`timescale 1ns / 1ps

module insertion_sorter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  isp_pkg::key_t        s_axis_tdata,  // [31:0] key
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output isp_pkg::key_t        m_axis_tdata,  // [31:0] sorted_key
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser   // [0] overflowed
);
	import isp_pkg::*;

	logic      state_q;
	logic      drop_q;
	logic      run_ovf_q;
	logic      m_vld_q;
	key_t      m_key_q;
	logic      m_last_q;
	logic      m_ovf_q;

	isp_link_t links [STORE_DEPTH];
	isp_ctrl_t ctrl;
	logic      acc;
	logic      full;
	logic      load;
	logic      last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign full          = links[STORE_DEPTH-1].vld;
	assign load          = (state_q == ST_DRAIN) && (!m_vld_q || m_axis_tready);
	assign last          = !links[1].vld;

	assign ctrl.ins   = acc && !full;
	assign ctrl.shift = load;
	assign ctrl.key   = s_axis_tdata;

	genvar gi;
	generate
		for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
			isp_link_t lower;
			isp_link_t upper;
			if (gi == 0) begin : g_bot
				assign lower = '{vld: 1'b1, gt: 1'b0, key: '0};
			end else begin : g_mid
				assign lower = links[gi-1];
			end
			if (gi == STORE_DEPTH-1) begin : g_top
				assign upper = '0;
			end else begin : g_low
				assign upper = links[gi+1];
			end
			isp_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.lower (lower),
				.upper (upper),
				.link  (links[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			drop_q    <= 1'b0;
			run_ovf_q <= 1'b0;
			m_vld_q   <= 1'b0;
		end else begin
			if (acc) begin
				if (s_axis_tlast) begin
					// close the run: latch its overflow and start the drain
					run_ovf_q <= drop_q || full;
					drop_q    <= 1'b0;
					state_q   <= ST_DRAIN;
				end else if (full) begin
					drop_q <= 1'b1;
				end
			end
			if (load) begin
				m_vld_q <= 1'b1;
				if (last) begin
					state_q <= ST_IDLE;
				end
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_key_q  <= links[0].key;
			m_last_q <= last;
			m_ovf_q  <= run_ovf_q;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_key_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_ovf_q;

endmodule

// ===== rtl/core/isp_cell.sv =====
// One cell of the insertion chain: holds one key, takes the new key or one from its lower or upper neighbour.
`timescale 1ns / 1ps

module isp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  isp_pkg::isp_ctrl_t ctrl,
	input  isp_pkg::isp_link_t lower,
	input  isp_pkg::isp_link_t upper,
	output isp_pkg::isp_link_t link
);
	import isp_pkg::*;

	logic vld_q;
	key_t key_q;
	logic gt;
	logic take;

	// Strictly greater: an equal key stays below the newcomer
	assign gt   = vld_q && (key_q > ctrl.key);
	assign take = ctrl.ins && (gt || (!vld_q && lower.vld));

	assign link.vld = vld_q;
	assign link.gt  = gt;
	assign link.key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= upper.vld;
		end else if (take) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= upper.key;
		end else if (take) begin
			// move the lower key up when it is larger, else take the new key
			key_q <= lower.gt ? lower.key : ctrl.key;
		end
	end

endmodule

// ===== rtl/core/isp_checker.sv =====
// Port-level checks for the insertion sorter, bound to the top level.
`timescale 1ns / 1ps

module isp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_axis_tvalid,
	input logic          s_axis_tready,
	input logic          s_axis_tlast,
	input logic          m_axis_tvalid,
	input logic          m_axis_tready,
	input isp_pkg::key_t m_axis_tdata,
	input logic          m_axis_tlast,
	input logic          m_axis_tuser
);
	import isp_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// the last key of a run closes the input until the drain ends
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("request taken right after last key");

	// results come out back to back and in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && (m_axis_tdata >= $past(m_axis_tdata))))
		else $error("results out of order");

	// no request is taken while a run is still draining
	a_no_accept_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("request taken during drain");

	// the overflow flag is constant over one run
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tuser == $past(m_axis_tuser)))
		else $error("overflow flag changed within a run");

endmodule

bind insertion_sorter_unit isp_checker u_isp_checker (.*);

// ===== tb/insertion_sorter_unit_test.sv =====
// Testbench for the insertion sorter: directed, overflow, random and back-pressure runs.
`timescale 1ns / 1ps

module insertion_sorter_unit_test;
	import isp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = STORE_DEPTH + 8;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		key_t key;
		logic run_end;
		logic overflowed;
	} sorted_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	key_t s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	key_t m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	key_t        run_store [STORE_DEPTH];
	int          run_count = 0;
	logic        run_dropped = 1'b0;
	sorted_res_t pending_sorted [$];

	int   send_idle_pct = 0;
	int   ready_stall_pct = 0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   idle_cycles = 0;
	int   errors = 0;

	insertion_sorter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Insert one key into the sorted run; on the last key, queue the whole run in order.
	function automatic void place_key(key_t k, logic last);
		int pos;
		if (run_count < STORE_DEPTH) begin
			pos = run_count;
			// equal keys stay below the new one
			while (pos > 0 && run_store[pos-1] > k) begin
				run_store[pos] = run_store[pos-1];
				pos--;
			end
			run_store[pos] = k;
			run_count++;
		end else begin
			run_dropped = 1'b1;
		end
		if (last) begin
			for (int i = 0; i < run_count; i++)
				pending_sorted.push_back('{key: run_store[i], run_end: (i == run_count - 1),
					overflowed: run_dropped});
			run_count = 0;
			run_dropped = 1'b0;
		end
	endfunction

	function automatic key_t rand_key();
		case ($urandom_range(9))
			0: return {1'b1, 31'd0};
			1: return {1'b0, {31{1'b1}}};
			// narrow range to get plenty of equal keys
			2, 3, 4: return key_t'($urandom_range(16)) - key_t'(8);
			default: return key_t'($urandom);
		endcase
	endfunction

	task automatic send_key(key_t k, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= k;
		s_axis_tlast  <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		place_key(k, last);
	endtask

	task automatic send_run(int len);
		for (int i = 1; i <= len; i++)
			send_key(rand_key(), i == len);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		send_key({1'b1, 31'd0}, 1'b1);
		send_key({1'b0, {31{1'b1}}}, 1'b1);
		send_key(32'sh0000_0000, 1'b0);
		send_key(-32'sd1, 1'b0);
		send_key(32'sd1, 1'b0);
		send_key({1'b0, {31{1'b1}}}, 1'b0);
		send_key({1'b1, 31'd0}, 1'b0);
		send_key(32'sh5555_5555, 1'b0);
		send_key(32'shAAAA_AAAA, 1'b0);
		send_key(-32'sd1, 1'b0);
		send_key(32'sh0000_0000, 1'b1);
		for (int v = 5; v >= 1; v--)
			send_key(key_t'(v), v == 1);
		for (int v = 1; v <= 4; v++)
			send_key(key_t'(v), v == 4);
	endtask

	// Overrun the store so a plain key and then the final key itself are dropped.
	task automatic test_overflow();
		send_run(STORE_DEPTH + 2);
	endtask

	task automatic test_random_runs(int idle_pct, int stall_pct, int n_keys);
		int sent;
		int len;
		send_idle_pct = idle_pct;
		ready_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_keys) begin
			len = $urandom_range(1, 12);
			send_run(len);
			sent += len;
		end
	endtask

	// Hold the receiver off while two runs are offered, so the drain stalls the input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		s_axis_tvalid <= 1'b0;
		hold_req <= 1'b1;
		do begin
			@(posedge clk);
		end while (hold_left == 0);
		hold_req <= 1'b0;
		send_run(8);
		send_run(8);
	endtask

	// Receiver: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		sorted_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_sorted.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result: expected none, got key=%0d last=%b ovf=%b",
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = pending_sorted.pop_front();
				if (m_axis_tdata !== want.key || m_axis_tlast !== want.run_end
						|| m_axis_tuser !== want.overflowed) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: mismatch: expected key=%0d last=%b ovf=%b, got key=%0d last=%b ovf=%b",
							$time, want.key, want.run_end, want.overflowed,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end
			end
		end
	end

	// Watchdog: end the run when no request moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("insertion_sorter_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random_runs(0, 0, 14);
		test_random_runs(62, 0, 14);
		test_random_runs(0, 62, 14);
		test_random_runs(27, 27, 14);
		test_backpressure();
		s_axis_tvalid <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("insertion_sorter_unit test passed");
		end else begin
			$display("insertion_sorter_unit test failed");
		end
		$finish;
	end

endmodule

// ===== insertion_sorter_unit.f =====
rtl/core/isp_pkg.sv
rtl/core/isp_cell.sv
rtl/core/insertion_sorter_unit.sv
rtl/core/isp_checker.sv
tb/insertion_sorter_unit_test.sv
